// ----- hw/rtl/frnns_pkg.sv -----
// ----------------------------------------------------------------------------
// frnns_pkg
// Shared widths, constants and types for the fixed-radius neighbour search.
// ----------------------------------------------------------------------------
package frnns_pkg;

  localparam int NUM_POINTS = 64;
  localparam int SLOT_W     = 6;
  localparam int COORD_W    = 15;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 1;

  localparam logic [COORD_W-1:0] RADIUS_RESET = COORD_W'(2560);
  localparam logic [SQ_W-1:0]    R2_RESET     = SQ_W'(2560 * 2560);

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // one stored point as held in a cell
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // one step of a query walk entering the distance pipeline
  typedef struct packed {
    logic               step;
    logic               pvld;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               tail;
  } walk_t;

  // outcome of one step
  typedef struct packed {
    logic               step;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               tail;
  } match_t;

endpackage

// ----- hw/rtl/frnns_cell.sv -----
// ----------------------------------------------------------------------------
// frnns_cell
// One slot of the point ring: loads on a store, passes its point on a shift.
// ----------------------------------------------------------------------------
module frnns_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        shift,
  input  logic [frnns_pkg::COORD_W-1:0] load_x,
  input  logic [frnns_pkg::COORD_W-1:0] load_y,
  input  frnns_pkg::point_t           nbr,
  output frnns_pkg::point_t           pt
);
  import frnns_pkg::*;

  // valid bit is cleared by reset; coordinates are undefined until written
  always_ff @(posedge clk) begin
    if (rst) begin
      pt.vld <= 1'b0;
    end else if (load) begin
      pt.vld <= 1'b1;
    end else if (shift) begin
      pt.vld <= nbr.vld;
    end
    if (load) begin
      pt.x <= load_x;
      pt.y <= load_y;
    end else if (shift) begin
      pt.x <= nbr.x;
      pt.y <= nbr.y;
    end
  end

endmodule

// ----- hw/rtl/frnns_dist.sv -----
// ----------------------------------------------------------------------------
// frnns_dist
// Three-stage squared distance test: abs diff, square, sum and compare.
// ----------------------------------------------------------------------------
module frnns_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  frnns_pkg::walk_t             in_step,
  input  logic [frnns_pkg::COORD_W-1:0] qx,
  input  logic [frnns_pkg::COORD_W-1:0] qy,
  input  logic [frnns_pkg::SQ_W-1:0]    r2,
  output frnns_pkg::match_t            out
);
  import frnns_pkg::*;

  walk_t              s1;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  walk_t              s2;
  logic [SQ_W-1:0]    sqx;
  logic [SQ_W-1:0]    sqy;
  logic [SUM_W-1:0]   d2;

  assign d2 = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.step  <= 1'b0;
      s2.step  <= 1'b0;
      out.step <= 1'b0;
    end else begin
      s1.step  <= in_step.step;
      s2.step  <= s1.step;
      out.step <= s2.step;
    end
    // stage 1: absolute differences
    s1.pvld <= in_step.pvld;
    s1.slot <= in_step.slot;
    s1.x    <= in_step.x;
    s1.y    <= in_step.y;
    s1.tail <= in_step.tail;
    dx      <= (in_step.x >= qx) ? (in_step.x - qx) : (qx - in_step.x);
    dy      <= (in_step.y >= qy) ? (in_step.y - qy) : (qy - in_step.y);
    // stage 2: squares
    s2.pvld <= s1.pvld;
    s2.slot <= s1.slot;
    s2.x    <= s1.x;
    s2.y    <= s1.y;
    s2.tail <= s1.tail;
    sqx     <= SQ_W'(dx) * SQ_W'(dx);
    sqy     <= SQ_W'(dy) * SQ_W'(dy);
    // stage 3: strictly inside the radius
    out.hit  <= s2.pvld && (d2 < {1'b0, r2});
    out.slot <= s2.slot;
    out.x    <= s2.x;
    out.y    <= s2.y;
    out.tail <= s2.tail;
  end

endmodule

// ----- hw/rtl/fixed_radius_neighbor_search_core.sv -----
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_search_core
// Brute-force 2-D fixed-radius neighbour search over a ring of point cells.
// ----------------------------------------------------------------------------
// Store item: busy stays low, no result.
// Query item: busy after acceptance through the walk and the drain of the
//   pipeline, so no new item is taken until then; the ring rotates one slot
//   per cycle past the single distance unit. A hit is held until the next
//   hit arrives or the walk ends; final result on the first cycle with busy low.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset (rst, synchronous): all slots invalid, radius 10.0, controller idle.
// ----------------------------------------------------------------------------
module fixed_radius_neighbor_search_core (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          cfg_we,
  input  logic [frnns_pkg::COORD_W-1:0] cfg_wdata,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [frnns_pkg::SLOT_W-1:0]  slot,
  input  logic [frnns_pkg::COORD_W-1:0] x_coord,
  input  logic [frnns_pkg::COORD_W-1:0] y_coord,
  // results
  output logic                          result_strobe,
  output logic                          hit,
  output logic [frnns_pkg::SLOT_W-1:0]  neighbor_slot,
  output logic [frnns_pkg::COORD_W-1:0] neighbor_x,
  output logic [frnns_pkg::COORD_W-1:0] neighbor_y,
  output logic                          last
);
  import frnns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t             state;
  logic [SLOT_W-1:0]  cnt;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [COORD_W-1:0] radius;
  logic [SQ_W-1:0]    r2;

  // Ring of cells: cell i takes from cell i+1, the last wraps to cell 0.
  // A query rotates exactly NUM_POINTS times, so slots realign afterwards
  // and a store can always write its cell directly by index.
  point_t pts [NUM_POINTS];
  logic   accept;
  logic   shift;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign shift  = (state == ST_WALK);

  for (genvar i = 0; i < NUM_POINTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % NUM_POINTS;
    frnns_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .load   (accept && (opcode == OP_STORE) && (slot == SLOT_W'(i))),
      .shift  (shift),
      .load_x (x_coord),
      .load_y (y_coord),
      .nbr    (pts[NXT]),
      .pt     (pts[i])
    );
  end

  // head of the ring feeds the distance pipeline; cnt is the slot index there
  walk_t  head;
  match_t m;

  always_comb begin
    head.step = shift;
    head.pvld = pts[0].vld;
    head.slot = cnt;
    head.x    = pts[0].x;
    head.y    = pts[0].y;
    head.tail = (cnt == SLOT_W'(NUM_POINTS - 1));
  end

  frnns_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_step (head),
    .qx      (qx),
    .qy      (qy),
    .r2      (r2),
    .out     (m)
  );

  // radius and its square; writes must come only while idle (the block does not
  // enforce it), so r2 is then settled long before any compare
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      r2     <= R2_RESET;
    end else begin
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      r2 <= SQ_W'(radius) * SQ_W'(radius);
    end
  end

  // One hit is held back so that the final one can carry last. A newer hit
  // pushes the held one out with last clear; the end of the walk flushes it
  // with last set, or gives the empty result if nothing was held.
  logic               pend_vld;
  logic [SLOT_W-1:0]  pend_slot;
  logic [COORD_W-1:0] pend_x;
  logic [COORD_W-1:0] pend_y;
  logic               end_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      qx            <= '0;
      qy            <= '0;
      pend_vld      <= 1'b0;
      pend_slot     <= '0;
      pend_x        <= '0;
      pend_y        <= '0;
      end_d         <= 1'b0;
      result_strobe <= 1'b0;
      hit           <= 1'b0;
      neighbor_slot <= '0;
      neighbor_x    <= '0;
      neighbor_y    <= '0;
      last          <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      end_d         <= m.step && m.tail;

      case (state)
        ST_IDLE: begin
          if (accept && (opcode == OP_QUERY)) begin
            qx    <= x_coord;
            qy    <= y_coord;
            cnt   <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          cnt <= cnt + SLOT_W'(1);
          if (cnt == SLOT_W'(NUM_POINTS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (end_d) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (m.step && m.hit) begin
        if (pend_vld) begin
          result_strobe <= 1'b1;
          hit           <= 1'b1;
          neighbor_slot <= pend_slot;
          neighbor_x    <= pend_x;
          neighbor_y    <= pend_y;
          last          <= 1'b0;
        end
        pend_vld  <= 1'b1;
        pend_slot <= m.slot;
        pend_x    <= m.x;
        pend_y    <= m.y;
      end

      // walk finished in the cycle before: no further hits can arrive now
      if (end_d) begin
        result_strobe <= 1'b1;
        hit           <= pend_vld;
        neighbor_slot <= pend_vld ? pend_slot : '0;
        neighbor_x    <= pend_vld ? pend_x : '0;
        neighbor_y    <= pend_vld ? pend_y : '0;
        last          <= 1'b1;
        pend_vld      <= 1'b0;
      end
    end
  end

endmodule

// ----- test/frnns_checker.sv -----
// ----------------------------------------------------------------------------
// frnns_checker
// Watches the command, configuration and result ports of the neighbour search
// core, predicts the neighbours of each query item and compares them in order.
// ----------------------------------------------------------------------------
module frnns_checker
  import frnns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata,
  input  logic               start,
  input  logic               busy,
  input  logic               opcode,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic               result_strobe,
  input  logic               hit,
  input  logic [SLOT_W-1:0]  neighbor_slot,
  input  logic [COORD_W-1:0] neighbor_x,
  input  logic [COORD_W-1:0] neighbor_y,
  input  logic               last,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } neighbour_t;

  logic [COORD_W-1:0]    pt_x [NUM_POINTS];
  logic [COORD_W-1:0]    pt_y [NUM_POINTS];
  logic [NUM_POINTS-1:0] pt_valid;
  logic [COORD_W-1:0]    radius_q;
  neighbour_t            neighbours_q [$];
  int                    mismatches = 0;

  assign errors = mismatches;

  initial pending = 0;

  function automatic logic [SUM_W-1:0] dist_sq(input logic [COORD_W-1:0] ax,
                                                input logic [COORD_W-1:0] ay,
                                                input logic [COORD_W-1:0] bx,
                                                input logic [COORD_W-1:0] by);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [SUM_W-1:0]   sq;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    sq = SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
    return sq;
  endfunction

  // walk valid slots in index order; strict compare on squared distance
  task automatic find_neighbours(input logic [COORD_W-1:0] qx,
                                 input logic [COORD_W-1:0] qy);
    neighbour_t      n;
    logic [SUM_W-1:0] r2;
    int              found;
    found = 0;
    r2 = SUM_W'(radius_q) * SUM_W'(radius_q);
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (pt_valid[i] && dist_sq(pt_x[i], pt_y[i], qx, qy) < r2) begin
        n.hit  = 1'b1;
        n.slot = SLOT_W'(i);
        n.x    = pt_x[i];
        n.y    = pt_y[i];
        n.last = 1'b0;
        neighbours_q.push_back(n);
        found++;
      end
    end
    if (found == 0) begin
      n = '0;
      n.last = 1'b1;
      neighbours_q.push_back(n);
    end else begin
      neighbours_q[neighbours_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_result();
    neighbour_t want;
    if (neighbours_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("checker: unexpected result hit=%0d slot=%0d x=%0d y=%0d last=%0d",
                 hit, neighbor_slot, neighbor_x, neighbor_y, last);
    end else begin
      want = neighbours_q.pop_front();
      if (hit !== want.hit || neighbor_slot !== want.slot || neighbor_x !== want.x ||
          neighbor_y !== want.y || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("checker: mismatch exp hit=%0d slot=%0d x=%0d y=%0d last=%0d",
                   want.hit, want.slot, want.x, want.y, want.last,
                   " got hit=%0d slot=%0d x=%0d y=%0d last=%0d",
                   hit, neighbor_slot, neighbor_x, neighbor_y, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      radius_q = RADIUS_RESET;
      pt_valid = '0;
      neighbours_q.delete();
    end else begin
      // results first: a query may be taken on the edge of the previous final result
      if (result_strobe)
        check_result();
      if (cfg_we)
        radius_q = cfg_wdata;
      if (start && !busy) begin
        if (opcode == OP_STORE) begin
          if (slot < NUM_POINTS) begin
            pt_x[slot]     = x_coord;
            pt_y[slot]     = y_coord;
            pt_valid[slot] = 1'b1;
          end
        end else begin
          find_neighbours(x_coord, y_coord);
        end
      end
    end
    pending <= neighbours_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives store and query items into the neighbour search core, changes the
// radius between phases and gives the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
  import frnns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX = 25600;
  // longest quiet spell: a full query walk plus sender gaps, several times over
  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COORD_W-1:0] cfg_wdata;
  logic               start;
  logic               busy;
  logic               opcode;
  logic [SLOT_W-1:0]  slot;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic               result_strobe;
  logic               hit;
  logic [SLOT_W-1:0]  neighbor_slot;
  logic [COORD_W-1:0] neighbor_x;
  logic [COORD_W-1:0] neighbor_y;
  logic               last;
  int                 errors;
  int                 pending;

  // sender idle probability per cycle in percent, changed per phase
  int                 gap_pct = 0;

  // shadow of stored points, only used to aim queries at them
  int                    shadow_x [NUM_POINTS];
  int                    shadow_y [NUM_POINTS];
  logic [NUM_POINTS-1:0] shadow_valid = '0;

  fixed_radius_neighbor_search_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .slot          (slot),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .result_strobe (result_strobe),
    .hit           (hit),
    .neighbor_slot (neighbor_slot),
    .neighbor_x    (neighbor_x),
    .neighbor_y    (neighbor_y),
    .last          (last)
  );

  frnns_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .slot          (slot),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .result_strobe (result_strobe),
    .hit           (hit),
    .neighbor_slot (neighbor_slot),
    .neighbor_x    (neighbor_x),
    .neighbor_y    (neighbor_y),
    .last          (last),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: any accepted item, register write or result restarts the count
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (start && !busy) || result_strobe || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // one item: idle cycles with start low, then hold until busy is low at an edge
  task automatic send_item(input logic op, input int s, input int x, input int y);
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    opcode  <= op;
    slot    <= SLOT_W'(s);
    x_coord <= COORD_W'(x);
    y_coord <= COORD_W'(y);
    do @(posedge clk); while (busy);
    if (op == OP_STORE) begin
      shadow_x[s]     = x;
      shadow_y[s]     = y;
      shadow_valid[s] = 1'b1;
    end
  endtask

  // wait until the core is idle and every predicted result has been seen
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radius(input int r);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= COORD_W'(r);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int near(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // clustered stores and queries so that hits are common at any radius;
  // a tenth of the items are uniform noise
  task automatic run_phase(input int items, input int r, input int pct);
    int cx [3];
    int cy [3];
    int spread;
    int k;
    int pick;
    int qx;
    int qy;
    set_radius(r);
    gap_pct = pct;
    spread  = r + r / 2 + 8;
    for (int c = 0; c < 3; c++) begin
      cx[c] = $urandom_range(0, COORD_MAX);
      cy[c] = $urandom_range(0, COORD_MAX);
    end
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 2);
      if (pick < 45) begin
        send_item(OP_STORE, $urandom_range(0, NUM_POINTS - 1),
                  near(cx[k], spread), near(cy[k], spread));
      end else if (pick < 90) begin
        if (shadow_valid != '0 && $urandom_range(0, 99) < 35) begin
          // aim at a stored point, sometimes one step off
          do k = $urandom_range(0, NUM_POINTS - 1); while (!shadow_valid[k]);
          qx = near(shadow_x[k], $urandom_range(0, 1));
          qy = near(shadow_y[k], $urandom_range(0, 1));
        end else begin
          qx = near(cx[k], spread);
          qy = near(cy[k], spread);
        end
        send_item(OP_QUERY, $urandom_range(0, NUM_POINTS - 1), qx, qy);
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom_range(0, NUM_POINTS - 1),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
      // now and then hold off until every outstanding result is back
      if ($urandom_range(0, 99) < 4)
        drain();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    start     <= 1'b0;
    opcode    <= OP_STORE;
    slot      <= '0;
    x_coord   <= '0;
    y_coord   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset radius of 10.0
    send_item(OP_QUERY, 5, 100, 200);             // nothing stored yet: empty
    send_item(OP_STORE, 0, 0, 0);
    send_item(OP_STORE, 63, COORD_MAX, COORD_MAX);
    send_item(OP_STORE, 1, 2560, 0);              // exactly on the radius: no match
    send_item(OP_STORE, 2, 0, 2559);              // just inside
    send_item(OP_QUERY, 63, 0, 0);                // slot field ignored on a query
    send_item(OP_QUERY, 0, COORD_MAX, COORD_MAX);
    send_item(OP_QUERY, 0, 12800, 12800);         // empty
    send_item(OP_STORE, 2, 12800, 12800);         // rewrite replaces the old point
    send_item(OP_QUERY, 0, 12800, 12800);
    send_item(OP_QUERY, 0, 1, 1);
    send_item(OP_STORE, 42, 21845, 10922);        // alternating bit patterns
    send_item(OP_STORE, 21, 10922, 21845);
    send_item(OP_STORE, 31, 16383, 16384);
    send_item(OP_QUERY, 21, 21845, 10922);
    send_item(OP_QUERY, 42, 16383, 16383);

    // zero radius: every query comes back empty, even on a stored point
    set_radius(0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 12800, 12800);

    // largest radius: most stored points match
    set_radius(COORD_MAX);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 12800, 12800);
    send_item(OP_QUERY, 0, COORD_MAX, 0);

    // random part: sender gaps 28 %, then 49 %, then none
    run_phase(33, $urandom_range(1500, 4000), 28);
    run_phase(33, 1, 49);                         // only exact coincidences match
    run_phase(33, $urandom_range(5000, COORD_MAX), 0);

    drain();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
